// File: hw/rtl/bdq_pkg.sv
// ---------------------------------------------------------------------------
// bdq_pkg
// Shared codes, field widths and the controller/datapath bundles of the
// bounded deque with search.
// ---------------------------------------------------------------------------
package bdq_pkg;

	localparam int FUNC_W = 3;
	localparam int VAL_W  = 32;
	localparam int STAT_W = 3;
	localparam int POS_W  = 7;

	// function codes
	localparam logic [FUNC_W-1:0] FN_PUSH_FRONT = 3'd0;
	localparam logic [FUNC_W-1:0] FN_PUSH_BACK  = 3'd1;
	localparam logic [FUNC_W-1:0] FN_POP_FRONT  = 3'd2;
	localparam logic [FUNC_W-1:0] FN_SEARCH     = 3'd3;
	localparam logic [FUNC_W-1:0] FN_READ_FWD   = 3'd4;
	localparam logic [FUNC_W-1:0] FN_READ_BWD   = 3'd5;

	// result status codes
	localparam logic [STAT_W-1:0] ST_DONE     = 3'd0;
	localparam logic [STAT_W-1:0] ST_FULL     = 3'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd2;
	localparam logic [STAT_W-1:0] ST_FOUND    = 3'd3;
	localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd4;

	// what the output register loads
	localparam logic [1:0] EM_NONE  = 2'd0;
	localparam logic [1:0] EM_STAT  = 2'd1;	// status only, last set
	localparam logic [1:0] EM_FOUND = 2'd2;	// search hit, position of s1 entry
	localparam logic [1:0] EM_ENTRY = 2'd3;	// readout of s1 entry

	typedef struct packed {
		logic              push_front;
		logic              push_back;
		logic              pop;
		logic              walk_start;
		logic              issue;
		logic              finish;
		logic              backward;
		logic [1:0]        em_sel;
		logic [STAT_W-1:0] em_status;
	} cmd_t;

	typedef struct packed {
		logic out_free;
		logic full;
		logic empty;
		logic pend;
		logic match;
		logic last;
		logic walk_more;
	} sts_t;

endpackage

// File: hw/rtl/bdq_ctrl.sv
// ---------------------------------------------------------------------------
// bdq_ctrl
// Controller: decodes the accepted item and sequences the walk used by
// search and readout.
// ---------------------------------------------------------------------------
module bdq_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [bdq_pkg::FUNC_W-1:0]  func,
	input  bdq_pkg::sts_t               sts,
	output bdq_pkg::cmd_t               cmd
);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_WALK = 1'b1;

	logic                       state_q;
	logic                       state_d;
	logic [bdq_pkg::FUNC_W-1:0] func_q;
	logic                       fire;
	logic                       consume;

	assign in_ready = (state_q == S_IDLE) && sts.out_free;
	assign fire     = in_valid && in_ready;
	assign consume  = sts.pend && sts.out_free;

	always_comb begin
		cmd          = '0;
		state_d      = state_q;
		cmd.backward = (func_q == bdq_pkg::FN_READ_BWD);
		unique case (state_q)
			S_IDLE: begin
				if (fire) begin
					unique case (func)
						bdq_pkg::FN_PUSH_FRONT, bdq_pkg::FN_PUSH_BACK: begin
							cmd.em_sel = bdq_pkg::EM_STAT;
							if (sts.full) begin
								cmd.em_status = bdq_pkg::ST_FULL;
							end else begin
								cmd.em_status  = bdq_pkg::ST_DONE;
								cmd.push_front = (func == bdq_pkg::FN_PUSH_FRONT);
								cmd.push_back  = (func == bdq_pkg::FN_PUSH_BACK);
							end
						end
						bdq_pkg::FN_POP_FRONT: begin
							cmd.em_sel = bdq_pkg::EM_STAT;
							if (sts.empty) begin
								cmd.em_status = bdq_pkg::ST_EMPTY;
							end else begin
								cmd.em_status = bdq_pkg::ST_DONE;
								cmd.pop       = 1'b1;
							end
						end
						bdq_pkg::FN_SEARCH: begin
							if (sts.empty) begin
								cmd.em_sel    = bdq_pkg::EM_STAT;
								cmd.em_status = bdq_pkg::ST_NOTFOUND;
							end else begin
								cmd.walk_start = 1'b1;
								state_d        = S_WALK;
							end
						end
						bdq_pkg::FN_READ_FWD, bdq_pkg::FN_READ_BWD: begin
							if (sts.empty) begin
								cmd.em_sel    = bdq_pkg::EM_STAT;
								cmd.em_status = bdq_pkg::ST_EMPTY;
							end else begin
								cmd.walk_start = 1'b1;
								state_d        = S_WALK;
							end
						end
						default: begin
							// unused codes: dropped, no result
						end
					endcase
				end
			end
			S_WALK: begin
				cmd.issue = sts.walk_more && (!sts.pend || consume);
				if (consume) begin
					if (func_q == bdq_pkg::FN_SEARCH) begin
						if (sts.match) begin
							cmd.em_sel    = bdq_pkg::EM_FOUND;
							cmd.em_status = bdq_pkg::ST_FOUND;
							cmd.finish    = 1'b1;
						end else if (sts.last) begin
							cmd.em_sel    = bdq_pkg::EM_STAT;
							cmd.em_status = bdq_pkg::ST_NOTFOUND;
							cmd.finish    = 1'b1;
						end
					end else begin
						cmd.em_sel    = bdq_pkg::EM_ENTRY;
						cmd.em_status = bdq_pkg::ST_DONE;
						cmd.finish    = sts.last;
					end
				end
				if (cmd.finish) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			func_q <= func;
		end
	end

endmodule

// File: hw/rtl/bdq_dp.sv
// ---------------------------------------------------------------------------
// bdq_dp
// Datapath: ring store, front/count registers, walk pointer, read stage
// and the output register.
// ---------------------------------------------------------------------------
module bdq_dp #(
	parameter int CAPACITY = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  bdq_pkg::cmd_t                     cmd,
	output bdq_pkg::sts_t                     sts,
	input  logic signed [bdq_pkg::VAL_W-1:0]  value,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [bdq_pkg::STAT_W-1:0]        status,
	output logic [bdq_pkg::POS_W-1:0]         position,
	output logic signed [bdq_pkg::VAL_W-1:0]  entry_value,
	output logic                              last
);

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam logic [IDX_W:0]   CAP_X   = (IDX_W + 1)'(CAPACITY);
	localparam logic [IDX_W-1:0] IDX_TOP = IDX_W'(CAPACITY - 1);
	localparam logic [CNT_W-1:0] CAP_C   = CNT_W'(CAPACITY);

	logic [bdq_pkg::VAL_W-1:0] mem [CAPACITY];

	logic [IDX_W-1:0]          front_q;
	logic [CNT_W-1:0]          count_q;
	logic [CNT_W-1:0]          k_q;
	logic [bdq_pkg::VAL_W-1:0] key_q;
	logic                      pend_s1;
	logic [IDX_W-1:0]          off_s1;
	logic                      last_s1;
	logic [bdq_pkg::VAL_W-1:0] rdata_s1;
	logic                      out_vld_q;

	logic [IDX_W-1:0] front_dec;
	logic [IDX_W-1:0] front_inc;
	logic [IDX_W-1:0] off;
	logic [IDX_W:0]   rd_sum;
	logic [IDX_W-1:0] rd_addr;
	logic [IDX_W:0]   bk_sum;
	logic [IDX_W-1:0] bk_addr;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	logic             out_free;

	assign front_dec = (front_q == '0) ? IDX_TOP : front_q - IDX_W'(1);
	assign front_inc = (front_q == IDX_TOP) ? '0 : front_q + IDX_W'(1);

	// offset of the entry being read, from the front
	assign off = cmd.backward ? IDX_W'(count_q - CNT_W'(1) - k_q) : k_q[IDX_W-1:0];

	assign rd_sum  = {1'b0, front_q} + {1'b0, off};
	assign rd_addr = (rd_sum >= CAP_X) ? IDX_W'(rd_sum - CAP_X) : rd_sum[IDX_W-1:0];

	// back slot: count is below capacity whenever a push goes through
	assign bk_sum  = {1'b0, front_q} + {1'b0, count_q[IDX_W-1:0]};
	assign bk_addr = (bk_sum >= CAP_X) ? IDX_W'(bk_sum - CAP_X) : bk_sum[IDX_W-1:0];

	assign wr_en   = cmd.push_front || cmd.push_back;
	assign wr_addr = cmd.push_front ? front_dec : bk_addr;

	assign out_free = !out_vld_q || out_ready;

	always_comb begin
		sts           = '0;
		sts.out_free  = out_free;
		sts.full      = (count_q == CAP_C);
		sts.empty     = (count_q == '0);
		sts.pend      = pend_s1;
		sts.match     = (rdata_s1 == key_q);
		sts.last      = last_s1;
		sts.walk_more = (k_q < count_q);
	end

	// store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= value;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			rdata_s1 <= mem[rd_addr];
			off_s1   <= off;
			last_s1  <= (k_q + CNT_W'(1) == count_q);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.walk_start) begin
			key_q <= value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			count_q <= '0;
			k_q     <= '0;
			pend_s1 <= 1'b0;
		end else begin
			if (cmd.push_front) begin
				front_q <= front_dec;
			end else if (cmd.pop) begin
				front_q <= front_inc;
			end
			if (wr_en) begin
				count_q <= count_q + CNT_W'(1);
			end else if (cmd.pop) begin
				count_q <= count_q - CNT_W'(1);
			end
			if (cmd.walk_start) begin
				k_q <= '0;
			end else if (cmd.issue) begin
				k_q <= k_q + CNT_W'(1);
			end
			if (cmd.finish || cmd.walk_start) begin
				pend_s1 <= 1'b0;
			end else if (cmd.issue) begin
				pend_s1 <= 1'b1;
			end else if (cmd.em_sel != bdq_pkg::EM_NONE || (pend_s1 && out_free)) begin
				pend_s1 <= 1'b0;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.em_sel != bdq_pkg::EM_NONE) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.em_sel != bdq_pkg::EM_NONE) begin
			status <= cmd.em_status;
			case (cmd.em_sel)
				bdq_pkg::EM_FOUND: begin
					position    <= bdq_pkg::POS_W'(off_s1) + bdq_pkg::POS_W'(1);
					entry_value <= '0;
					last        <= 1'b1;
				end
				bdq_pkg::EM_ENTRY: begin
					position    <= bdq_pkg::POS_W'(off_s1) + bdq_pkg::POS_W'(1);
					entry_value <= rdata_s1;
					last        <= last_s1;
				end
				default: begin
					position    <= '0;
					entry_value <= '0;
					last        <= 1'b1;
				end
			endcase
		end
	end

	assign out_valid = out_vld_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_C)
		else $error("entry count above capacity");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.em_sel != bdq_pkg::EM_NONE) |-> (!out_vld_q || out_ready))
		else $error("result loaded over an untaken result");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.push_front || cmd.push_back) |=> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("push did not grow the count");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> (count_q != '0))
		else $error("pop on an empty store");

	a_issue_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |-> (k_q < count_q))
		else $error("read issued past the last entry");
`endif

endmodule

// File: hw/rtl/bounded_deque_with_search_top.sv
// ---------------------------------------------------------------------------
// bounded_deque_with_search_top
// Bounded double-ended queue of signed 32-bit values with linear search.
// Holds up to CAPACITY values in a ring store addressed by a front index and
// an entry count. func selects push front, push back, pop front, search,
// read forward or read backward; codes 6 and 7 are dropped with no result.
// A push into a full store or a pop from an empty one changes nothing and
// reports it in status. Search returns the 1-based position of the first
// match from the front. A readout returns one item per entry, last set on
// the final one; an empty readout returns a single empty item. Push, pop
// and any item answered without touching the store are taken as soon as the
// output register is free. Search and readout walk the stored entries through
// the store's single registered read port, one entry per cycle while the
// downstream side keeps ready high. A new item is accepted only after the
// previous item has put its final result into the output register.
// ---------------------------------------------------------------------------
module bounded_deque_with_search_top #(
	parameter int CAPACITY = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [bdq_pkg::FUNC_W-1:0]        func,
	input  logic signed [bdq_pkg::VAL_W-1:0]  value,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [bdq_pkg::STAT_W-1:0]        status,
	output logic [bdq_pkg::POS_W-1:0]         position,
	output logic signed [bdq_pkg::VAL_W-1:0]  entry_value,
	output logic                              last
);

	// command and status bundles between controller and datapath
	bdq_pkg::cmd_t cmd;
	bdq_pkg::sts_t sts;

	// controller: item decode and walk sequencing
	bdq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.func     (func),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath: ring store, pointers, read stage, output register
	bdq_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.value       (value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.position    (position),
		.entry_value (entry_value),
		.last        (last)
	);

endmodule

// File: verif/bounded_deque_with_search_top_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bounded_deque_with_search_top_tb
// Self-checking bench for the bounded deque with search. A short directed
// table covers the empty and full corners, extreme values and the unused
// function codes. It is followed by random fill/drain sequences with searches
// and readouts. Every accepted item runs through a bit-accurate deque
// predictor. Each result is checked against the oldest expected one.
// ---------------------------------------------------------------------------
module bounded_deque_with_search_top_tb;
	import bdq_pkg::*;

	localparam int DEPTH       = 16;
	localparam int N_RANDOM    = 375;	// random items that reach the deque
	localparam int N_QUIET     = 60;	// tail of the run with no idling
	localparam int HOLD_CYC    = 300;	// long receiver hold-off
	localparam int HOLD_AT     = 150;	// accepted items before the hold-off
	localparam int DRAIN_LIMIT = 20000;

	// function codes the block drops without a result
	localparam logic [FUNC_W-1:0] FN_UNUSED_6 = 3'd6;
	localparam logic [FUNC_W-1:0] FN_UNUSED_7 = 3'd7;

	typedef struct packed {
		logic [STAT_W-1:0]       st;
		logic [POS_W-1:0]        pos;
		logic signed [VAL_W-1:0] val;
		logic                    lst;
	} deque_res_t;

	localparam deque_res_t R_NONE  = '0;
	localparam deque_res_t R_DONE  = '{ST_DONE,     7'd0, 32'sd0, 1'b1};
	localparam deque_res_t R_FULL  = '{ST_FULL,     7'd0, 32'sd0, 1'b1};
	localparam deque_res_t R_EMPTY = '{ST_EMPTY,    7'd0, 32'sd0, 1'b1};
	localparam deque_res_t R_NOTF  = '{ST_NOTFOUND, 7'd0, 32'sd0, 1'b1};

	// One directed row. reps > 1 repeats the row with value + 0, 1, 2 ...
	// chk set: the typed result (t_cnt of them, 0 or 1) is expected instead
	// of the predictor's. The predictor still tracks the state.
	typedef struct packed {
		logic [FUNC_W-1:0]       fn;
		logic signed [VAL_W-1:0] val;
		logic [4:0]              reps;
		logic                    chk;
		logic                    t_cnt;
		deque_res_t              t_res;
	} dir_row_t;

	localparam int N_DIR = 22;
	localparam dir_row_t DIR_ROWS [N_DIR] = '{
		// empty deque right after reset
		'{FN_POP_FRONT,  32'sd0,           5'd1,  1'b1, 1'b1, R_EMPTY},
		'{FN_SEARCH,     32'sd0,           5'd1,  1'b1, 1'b1, R_NOTF},
		'{FN_READ_FWD,   32'sd0,           5'd1,  1'b1, 1'b1, R_EMPTY},
		'{FN_READ_BWD,   32'sd0,           5'd1,  1'b1, 1'b1, R_EMPTY},
		// unused codes: no result at all
		'{FN_UNUSED_6,   32'sd0,           5'd1,  1'b1, 1'b0, R_NONE},
		'{FN_UNUSED_7,   -32'sd1,          5'd1,  1'b1, 1'b0, R_NONE},
		// extreme values at both ends, front push wraps the ring
		'{FN_PUSH_BACK,  32'sh7fffffff,    5'd1,  1'b1, 1'b1, R_DONE},
		'{FN_PUSH_FRONT, 32'sh80000000,    5'd1,  1'b1, 1'b1, R_DONE},
		'{FN_PUSH_BACK,  32'sd0,           5'd1,  1'b1, 1'b1, R_DONE},
		'{FN_PUSH_FRONT, -32'sd1,          5'd1,  1'b1, 1'b1, R_DONE},
		'{FN_SEARCH,     32'sh80000000,    5'd1,  1'b0, 1'b0, R_NONE},
		'{FN_SEARCH,     32'sh7fffffff,    5'd1,  1'b0, 1'b0, R_NONE},
		'{FN_READ_FWD,   32'sd0,           5'd1,  1'b0, 1'b0, R_NONE},
		'{FN_READ_BWD,   32'sd0,           5'd1,  1'b0, 1'b0, R_NONE},
		'{FN_POP_FRONT,  32'sd0,           5'd1,  1'b1, 1'b1, R_DONE},
		// fill to capacity, then pushes at both ends get dropped
		'{FN_PUSH_BACK,  32'sh5a5a5a50,    5'd13, 1'b1, 1'b1, R_DONE},
		'{FN_PUSH_FRONT, 32'sd1,           5'd1,  1'b1, 1'b1, R_FULL},
		'{FN_PUSH_BACK,  32'sd2,           5'd1,  1'b1, 1'b1, R_FULL},
		// search hits the last entry; full readouts both ways
		'{FN_SEARCH,     32'sh5a5a5a5c,    5'd1,  1'b0, 1'b0, R_NONE},
		'{FN_SEARCH,     32'sd12345,       5'd1,  1'b1, 1'b1, R_NOTF},
		'{FN_READ_FWD,   32'sd0,           5'd1,  1'b0, 1'b0, R_NONE},
		'{FN_READ_BWD,   32'sd0,           5'd1,  1'b0, 1'b0, R_NONE}
	};

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_ready;
	logic [FUNC_W-1:0]       func;
	logic signed [VAL_W-1:0] value;
	logic                    out_valid;
	logic                    out_ready;
	logic [STAT_W-1:0]       status;
	logic [POS_W-1:0]        position;
	logic signed [VAL_W-1:0] entry_value;
	logic                    last;

	// deque predictor state
	logic signed [VAL_W-1:0] dq_store [DEPTH] = '{default: '0};
	int                      dq_front = 0;
	int                      dq_count = 0;

	deque_res_t op_results[$];       // results of the item just predicted
	deque_res_t pending_results[$];  // expected results still to arrive

	int errors     = 0;
	int n_accepted = 0;
	bit idle_on    = 1'b1;

	always #5 clk = ~clk;

	bounded_deque_with_search_top #(
		.CAPACITY(DEPTH)
	) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.func       (func),
		.value      (value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.position   (position),
		.entry_value(entry_value),
		.last       (last)
	);

	task automatic report_mismatch(input string msg);
		errors++;
		if (errors <= 40)
			$display("mismatch at %0t ns: %s", $time, msg);
	endtask

	// ring slot of the entry k places behind the front
	function automatic int slot(int k);
		int s;
		s = dq_front + k;
		if (s >= DEPTH)
			s -= DEPTH;
		return s;
	endfunction

	function automatic void add_result(logic [STAT_W-1:0] s, int p,
		logic signed [VAL_W-1:0] v, bit l);
		op_results.push_back('{s, POS_W'(p), v, l});
	endfunction

	// Apply one item to the predictor, leaving its results in op_results.
	task automatic model_op(input logic [FUNC_W-1:0] f, input logic signed [VAL_W-1:0] v);
		int k;
		int off;
		bit hit;
		op_results.delete();
		case (f)
			FN_PUSH_FRONT, FN_PUSH_BACK: begin
				if (dq_count >= DEPTH) begin
					add_result(ST_FULL, 0, '0, 1'b1);
				end else begin
					if (f == FN_PUSH_FRONT) begin
						dq_front = (dq_front == 0) ? DEPTH - 1 : dq_front - 1;
						dq_store[dq_front] = v;
					end else begin
						dq_store[slot(dq_count)] = v;
					end
					dq_count++;
					add_result(ST_DONE, 0, '0, 1'b1);
				end
			end
			FN_POP_FRONT: begin
				if (dq_count == 0) begin
					add_result(ST_EMPTY, 0, '0, 1'b1);
				end else begin
					dq_front = slot(1);
					dq_count--;
					add_result(ST_DONE, 0, '0, 1'b1);
				end
			end
			FN_SEARCH: begin
				// first match from the front wins
				hit = 1'b0;
				for (k = 0; k < dq_count && !hit; k++) begin
					if (dq_store[slot(k)] == v) begin
						hit = 1'b1;
						add_result(ST_FOUND, k + 1, '0, 1'b1);
					end
				end
				if (!hit)
					add_result(ST_NOTFOUND, 0, '0, 1'b1);
			end
			FN_READ_FWD, FN_READ_BWD: begin
				if (dq_count == 0) begin
					add_result(ST_EMPTY, 0, '0, 1'b1);
				end else begin
					for (k = 0; k < dq_count; k++) begin
						off = (f == FN_READ_FWD) ? k : dq_count - 1 - k;
						add_result(ST_DONE, off + 1, dq_store[slot(off)], k + 1 == dq_count);
					end
				end
			end
			default: ;	// unused codes: nothing happens
		endcase
	endtask

	// Values: mostly random, a small pool of repeats so searches see
	// duplicates, and the extremes. Search keys mostly hit a stored entry.
	function automatic logic signed [VAL_W-1:0] pick_value(bit as_key);
		int r;
		r = $urandom_range(0, 99);
		if (as_key && dq_count != 0 && r < 60)
			return dq_store[slot($urandom_range(0, dq_count - 1))];
		if (r < 75)
			return $urandom;
		if (r < 88)
			return int'($urandom_range(0, 3)) - 2;
		case ($urandom_range(0, 3))
			0:       return 32'sh80000000;
			1:       return 32'sh7fffffff;
			2:       return '0;
			default: return -32'sd1;
		endcase
	endfunction

	// Offer one item. Entered and left at a falling edge; valid stays up
	// with a fixed payload until the block takes the item.
	task automatic offer(input logic [FUNC_W-1:0] f, input logic signed [VAL_W-1:0] v,
		input bit chk, input bit t_cnt, input deque_res_t t_res);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 17)) @(negedge clk);
		end
		in_valid = 1'b1;
		func     = f;
		value    = v;
		do @(posedge clk); while (!in_ready);
		n_accepted++;
		model_op(f, v);
		if (chk) begin
			if (t_cnt)
				pending_results.push_back(t_res);
		end else begin
			foreach (op_results[i])
				pending_results.push_back(op_results[i]);
		end
		@(negedge clk);
	endtask

	// Receiver: random ready-low bursts, plus one long hold-off once enough
	// items are through, so the output register backs up and in_ready drops
	// while the sender keeps offering.
	initial begin
		int stall_left;
		bit hold_done;
		stall_left = 0;
		hold_done  = 1'b0;
		out_ready  = 1'b0;
		forever begin
			@(negedge clk);
			if (arst_n) begin
				if (!hold_done && n_accepted >= HOLD_AT) begin
					hold_done  = 1'b1;
					stall_left = HOLD_CYC;
				end else if (stall_left == 0 && idle_on && $urandom_range(0, 7) == 0) begin
					stall_left = $urandom_range(1, 17);
				end
				if (stall_left > 0) begin
					out_ready = 1'b0;
					stall_left--;
				end else begin
					out_ready = 1'b1;
				end
			end
		end
	end

	// Result checker: each accepted result against the oldest expectation.
	always @(posedge clk) begin
		deque_res_t got;
		deque_res_t want;
		if (arst_n && out_valid && out_ready) begin
			got = '{status, position, entry_value, last};
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result st=%0d pos=%0d val=%0d last=%0b",
					got.st, got.pos, got.val, got.lst));
			end else begin
				want = pending_results.pop_front();
				if (got.st !== want.st || got.pos !== want.pos ||
					got.val !== want.val || got.lst !== want.lst)
					report_mismatch($sformatf(
						"got st=%0d pos=%0d val=%0d last=%0b, want st=%0d pos=%0d val=%0d last=%0b",
						got.st, got.pos, got.val, got.lst,
						want.st, want.pos, want.val, want.lst));
			end
		end
	end

	// Stimulus and end of run.
	initial begin
		int n_real;
		int r;
		int wait_cyc;
		bit filling;
		logic [FUNC_W-1:0] f;
		logic signed [VAL_W-1:0] v;

		arst_n   = 1'b0;
		in_valid = 1'b0;
		func     = FN_PUSH_FRONT;
		value    = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed table
		foreach (DIR_ROWS[i])
			for (int k = 0; k < DIR_ROWS[i].reps; k++)
				offer(DIR_ROWS[i].fn, DIR_ROWS[i].val + k,
					DIR_ROWS[i].chk, DIR_ROWS[i].t_cnt, DIR_ROWS[i].t_res);

		// Random part: alternate fill and drain phases so the count sweeps
		// between empty and full. Lingering at full or empty lets dropped
		// pushes, empty pops and empty readouts show up now and then.
		filling = 1'b0;
		n_real  = 0;
		while (n_real < N_RANDOM) begin
			if (n_real >= N_RANDOM - N_QUIET)
				idle_on = 1'b0;
			if (filling && dq_count == DEPTH && $urandom_range(0, 3) == 0)
				filling = 1'b0;
			else if (!filling && dq_count == 0 && $urandom_range(0, 2) == 0)
				filling = 1'b1;
			r = $urandom_range(0, 99);
			if (r < (filling ? 45 : 15))
				f = $urandom_range(0, 1) ? FN_PUSH_BACK : FN_PUSH_FRONT;
			else if (r < 55)
				f = FN_POP_FRONT;
			else if (r < 75)
				f = FN_SEARCH;
			else if (r < 86)
				f = FN_READ_FWD;
			else if (r < 97)
				f = FN_READ_BWD;
			else
				f = $urandom_range(0, 1) ? FN_UNUSED_6 : FN_UNUSED_7;
			v = pick_value(f == FN_SEARCH);
			// dropped codes do not count toward the item budget
			if (f != FN_UNUSED_6 && f != FN_UNUSED_7)
				n_real++;
			offer(f, v, 1'b0, 1'b0, R_NONE);
		end
		in_valid = 1'b0;

		// let the last readout drain, then give stray results a chance to show
		for (wait_cyc = 0; wait_cyc < DRAIN_LIMIT && pending_results.size() != 0; wait_cyc++)
			@(posedge clk);
		if (pending_results.size() != 0)
			report_mismatch($sformatf("%0d expected results never arrived",
				pending_results.size()));
		repeat (DEPTH + 8) @(posedge clk);

		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// watchdog: far beyond the slowest legal run
	initial begin
		#20_000_000;
		$display("FAIL");
		$finish;
	end

endmodule

// File: bounded_deque_with_search_top.f
hw/rtl/bdq_pkg.sv
hw/rtl/bdq_ctrl.sv
hw/rtl/bdq_dp.sv
hw/rtl/bounded_deque_with_search_top.sv
verif/bounded_deque_with_search_top_tb.sv
